// ----- rtl/ipr_pkg.sv -----
// Shared constants, codes and control structs of the IPv4 range table lookup.
// No dependencies; every other file of the block refers to it by scoped name.
`default_nettype none

package ipr_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 4096;
  localparam int TADDR_W     = $clog2(TABLE_DEPTH);
  localparam int LH_W        = $clog2(TABLE_DEPTH + 1);

  // Fixed field widths
  localparam int ADDR_W  = 32;
  localparam int IDX_W   = 12;
  localparam int COUNT_W = 13;

  // Operation codes of an input beat
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Top level to search sequencer
  typedef struct packed {
    logic              start;
    logic [LH_W-1:0]   count;
    logic [ADDR_W-1:0] addr;
    logic              out_free;
  } srch_ctl_t;

  // Search sequencer to top level
  typedef struct packed {
    logic             busy;
    logic             done;
    logic             found;
    logic [IDX_W-1:0] match_index;
  } srch_sts_t;

endpackage

`default_nettype wire

// ----- rtl/ipr_in_if.sv -----
// Input channel of the range table lookup: valid/ready plus the item payload.
// Depends on ipr_pkg for field widths.
`default_nettype none

interface ipr_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [ipr_pkg::IDX_W-1:0]  entry_index;
  logic [ipr_pkg::ADDR_W-1:0] range_start;
  logic [ipr_pkg::ADDR_W-1:0] range_end;
  logic [ipr_pkg::ADDR_W-1:0] query_addr;

  modport source (output valid, op, entry_index, range_start, range_end, query_addr,
                  input ready);
  modport sink   (input valid, op, entry_index, range_start, range_end, query_addr,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/ipr_out_if.sv -----
// Result channel of the range table lookup: valid/ready plus found and index.
// Depends on ipr_pkg for field widths.
`default_nettype none

interface ipr_out_if;
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [ipr_pkg::IDX_W-1:0] match_index;

  modport source (output valid, found, match_index, input ready);
  modport sink   (input valid, found, match_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/ip_range_table_lookup_unit.sv -----
// Top level of the IPv4 range table lookup: config register, result register,
// table memory and search sequencer. Depends on ipr_pkg, ipr_in_if, ipr_out_if,
// ipr_mem and ipr_srch.
`default_nettype none

// The block holds up to 4096 address ranges {start, end}, sorted by start, in one
// synchronous memory. A load beat (op = 0) writes entry entry_index and returns
// found = 0, match_index = 0; it is accepted whenever the sequencer is idle and
// the result register is free or being drained. A query beat (op = 1) runs a
// binary search over the first record_count entries (saturated to the table
// depth) for the last entry whose start is not above query_addr, then checks
// query_addr against that entry's end. Each search level takes a memory read
// and then a compare in the shared comparator. No new beat is taken while a
// query is in flight. A finished result waits in the output register, and while
// it waits the input holds off too: the next beat is taken only once that
// register is empty or drains in the same cycle. Entries hold no reset value:
// a query must only touch loaded entries. Write record_count only while the
// block is idle.
module ip_range_table_lookup_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ipr_pkg::COUNT_W-1:0]  cfg_wdata_i,
  ipr_in_if.sink                            in_i,
  ipr_out_if.source                         out_o
);

  logic [ipr_pkg::COUNT_W-1:0] count_q;
  logic                        out_valid_q, out_valid_d;
  logic                        out_found_q, out_found_d;
  logic [ipr_pkg::IDX_W-1:0]   out_match_q, out_match_d;

  ipr_pkg::srch_ctl_t          srch_ctl;
  ipr_pkg::srch_sts_t          srch_sts;

  logic                        in_beat;
  logic                        load_beat;
  logic                        out_free;
  logic                        rd_en;
  logic [ipr_pkg::TADDR_W-1:0] rd_addr;
  logic [ipr_pkg::ADDR_W-1:0]  rd_start;
  logic [ipr_pkg::ADDR_W-1:0]  rd_end;
  logic                        wr_en;
  logic [ipr_pkg::LH_W-1:0]    count_sat;

  // Result register is free when empty or handing its beat over this cycle
  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = !srch_sts.busy && out_free;
  assign in_beat   = in_i.valid && in_i.ready;
  assign load_beat = in_beat && (in_i.op == ipr_pkg::OP_LOAD);

  // Drop loads aimed beyond the table
  assign wr_en = load_beat &&
                 (32'(in_i.entry_index) < 32'(ipr_pkg::TABLE_DEPTH));

  // Saturate the entry count to the table depth
  assign count_sat = (32'(count_q) > 32'(ipr_pkg::TABLE_DEPTH)) ?
                     ipr_pkg::LH_W'(ipr_pkg::TABLE_DEPTH) :
                     ipr_pkg::LH_W'(count_q);

  assign srch_ctl.start    = in_beat && (in_i.op == ipr_pkg::OP_QUERY);
  assign srch_ctl.count    = count_sat;
  assign srch_ctl.addr     = in_i.query_addr;
  assign srch_ctl.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // Load the result register from a load beat or a finished search; else drain
  always_comb begin
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_match_d = out_match_q;
    priority if (load_beat) begin
      out_valid_d = 1'b1;
      out_found_d = 1'b0;
      out_match_d = '0;
    end else if (srch_sts.done) begin
      out_valid_d = 1'b1;
      out_found_d = srch_sts.found;
      out_match_d = srch_sts.match_index;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q <= out_found_d;
    out_match_q <= out_match_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = out_found_q;
  assign out_o.match_index = out_match_q;

  ipr_mem u_mem (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (ipr_pkg::TADDR_W'(in_i.entry_index)),
    .wr_start_i (in_i.range_start),
    .wr_end_i   (in_i.range_end),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_start_o (rd_start),
    .rd_end_o   (rd_end)
  );

  ipr_srch u_srch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (srch_ctl),
    .sts_o      (srch_sts),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_start_i (rd_start),
    .rd_end_i   (rd_end)
  );

endmodule

`default_nettype wire

// ----- rtl/ipr_mem.sv -----
// Range table storage: one entry holds {start, end}, one write and one read port.
// Depends on ipr_pkg for depth and widths; read data is registered.
`default_nettype none

module ipr_mem (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic [ipr_pkg::TADDR_W-1:0] wr_addr_i,
  input  wire logic [ipr_pkg::ADDR_W-1:0]  wr_start_i,
  input  wire logic [ipr_pkg::ADDR_W-1:0]  wr_end_i,
  input  wire logic                        rd_en_i,
  input  wire logic [ipr_pkg::TADDR_W-1:0] rd_addr_i,
  output logic      [ipr_pkg::ADDR_W-1:0]  rd_start_o,
  output logic      [ipr_pkg::ADDR_W-1:0]  rd_end_o
);

  logic [2*ipr_pkg::ADDR_W-1:0] mem [ipr_pkg::TABLE_DEPTH];
  logic [2*ipr_pkg::ADDR_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_start_i, wr_end_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_start_o = rd_data_q[2*ipr_pkg::ADDR_W-1:ipr_pkg::ADDR_W];
  assign rd_end_o   = rd_data_q[ipr_pkg::ADDR_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/ipr_srch.sv -----
// Binary search sequencer with one shared 32-bit compare unit.
// Depends on ipr_pkg; drives the read port of ipr_mem.
`default_nettype none

module ipr_srch (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ipr_pkg::srch_ctl_t          ctl_i,
  output ipr_pkg::srch_sts_t               sts_o,
  output logic                             rd_en_o,
  output logic      [ipr_pkg::TADDR_W-1:0] rd_addr_o,
  input  wire logic [ipr_pkg::ADDR_W-1:0]  rd_start_i,
  input  wire logic [ipr_pkg::ADDR_W-1:0]  rd_end_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SRCH = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_END  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                     st_q, st_d;
  logic [ipr_pkg::LH_W-1:0]       lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [ipr_pkg::LH_W-1:0]       mid_c, cand_c;
  logic [ipr_pkg::ADDR_W-1:0]     addr_q, addr_d;
  logic                           found_q, found_d;
  logic [ipr_pkg::IDX_W-1:0]      match_q, match_d;
  logic [ipr_pkg::ADDR_W-1:0]     cmp_a, cmp_b;
  logic                           cmp_le;

  assign mid_c  = lo_q + ((hi_q - lo_q) >> 1);
  assign cand_c = lo_q - 1'b1;

  // Shared compare: start <= addr while halving, addr <= end on the final check
  assign cmp_a  = (st_q == ST_END) ? addr_q : rd_start_i;
  assign cmp_b  = (st_q == ST_END) ? rd_end_i : addr_q;
  assign cmp_le = (cmp_a <= cmp_b);

  always_comb begin
    st_d      = st_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    addr_d    = addr_q;
    found_d   = found_q;
    match_d   = match_q;
    rd_en_o   = 1'b0;
    rd_addr_o = ipr_pkg::TADDR_W'(mid_c);
    unique case (st_q)
      ST_IDLE: begin
        if (ctl_i.start) begin
          lo_d   = '0;
          hi_d   = ctl_i.count;
          addr_d = ctl_i.addr;
          st_d   = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (lo_q < hi_q) begin
          rd_en_o = 1'b1;
          mid_d   = mid_c;
          st_d    = ST_CMP;
        end else if (lo_q != '0) begin
          rd_en_o   = 1'b1;
          rd_addr_o = ipr_pkg::TADDR_W'(cand_c);
          st_d      = ST_END;
        end else begin
          found_d = 1'b0;
          match_d = '0;
          st_d    = ST_DONE;
        end
      end
      ST_CMP: begin
        if (cmp_le) begin
          lo_d = mid_q + 1'b1;
        end else begin
          hi_d = mid_q;
        end
        st_d = ST_SRCH;
      end
      ST_END: begin
        found_d = cmp_le;
        match_d = cmp_le ? ipr_pkg::IDX_W'(cand_c) : '0;
        st_d    = ST_DONE;
      end
      ST_DONE: begin
        if (ctl_i.out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    addr_q  <= addr_d;
    found_q <= found_d;
    match_q <= match_d;
  end

  assign sts_o.busy        = (st_q != ST_IDLE);
  assign sts_o.done        = (st_q == ST_DONE) && ctl_i.out_free;
  assign sts_o.found       = found_q;
  assign sts_o.match_index = match_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> st_q == ST_IDLE)
    else $error("search started while busy");

  a_lo_le_hi : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_CMP |=> lo_q <= hi_q)
    else $error("search window inverted");

  a_hi_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_SRCH |-> hi_q <= ipr_pkg::LH_W'(ipr_pkg::TABLE_DEPTH))
    else $error("search bound beyond table");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.done |=> st_q == ST_IDLE)
    else $error("sequencer did not release after result");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.done && !sts_o.found |-> sts_o.match_index == '0)
    else $error("miss carries nonzero index");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for ip_range_table_lookup_unit: loads range tables, runs
// address lookups and checks every result beat against an in-bench search model.
// Depends on ipr_pkg, ipr_in_if, ipr_out_if and the lookup unit RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One input beat, laid out in port order so a concatenation of the bus fits it.
  typedef struct packed {
    logic                       op;
    logic [ipr_pkg::IDX_W-1:0]  entry_index;
    logic [ipr_pkg::ADDR_W-1:0] range_start;
    logic [ipr_pkg::ADDR_W-1:0] range_end;
    logic [ipr_pkg::ADDR_W-1:0] query_addr;
  } range_beat_t;

  // One result beat.
  typedef struct packed {
    logic                      found;
    logic [ipr_pkg::IDX_W-1:0] match_index;
  } lookup_res_t;

  // Table shapes built by the stimulus.
  typedef enum int {FILL_SORTED, FILL_DUP_STARTS, FILL_SCRAMBLED} fill_style_e;

  localparam int RANDOM_ITEMS = 1650;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 100;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [ipr_pkg::COUNT_W-1:0] cfg_wdata_i;

  ipr_in_if  in_if ();
  ipr_out_if out_if ();

  ip_range_table_lookup_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Search model state: its own copy of the table and of record_count.
  logic [ipr_pkg::ADDR_W-1:0]  start_tbl [ipr_pkg::TABLE_DEPTH];
  logic [ipr_pkg::ADDR_W-1:0]  end_tbl   [ipr_pkg::TABLE_DEPTH];
  logic [ipr_pkg::COUNT_W-1:0] rec_count;

  // Stimulus-side view of the table, used only to aim queries at range edges.
  logic [ipr_pkg::ADDR_W-1:0]  plan_start [ipr_pkg::TABLE_DEPTH];
  logic [ipr_pkg::ADDR_W-1:0]  plan_end   [ipr_pkg::TABLE_DEPTH];

  range_beat_t beat_q [$];     // beats waiting for the driver
  lookup_res_t lookup_q [$];   // results owed by the block, oldest first
  range_beat_t next_beat;
  lookup_res_t want;
  int unsigned fail_cnt  = 0;
  int unsigned src_calm  = 0;
  int unsigned sink_calm = 0;
  int unsigned rand_items;

  // Apply one accepted beat to the model and return the result it owes.
  // A load writes the entry; a query halves [0, count) keeping the upper half
  // whenever the middle start is not above the address, then checks the end.
  function automatic lookup_res_t search_ranges(range_beat_t b);
    lookup_res_t r;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    r = '0;
    if (b.op == ipr_pkg::OP_LOAD) begin
      if (b.entry_index < ipr_pkg::TABLE_DEPTH) begin
        start_tbl[b.entry_index] = b.range_start;
        end_tbl[b.entry_index]   = b.range_end;
      end
    end else begin
      lo = 0;
      hi = (rec_count > ipr_pkg::TABLE_DEPTH) ? ipr_pkg::TABLE_DEPTH : rec_count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (start_tbl[mid] <= b.query_addr) lo = mid + 1;
        else hi = mid;
      end
      if (lo > 0 && b.query_addr <= end_tbl[lo-1]) begin
        r.found       = 1'b1;
        r.match_index = ipr_pkg::IDX_W'(lo - 1);
      end
    end
    return r;
  endfunction

  // Idle with a chance of 22 in 100, except during a calm stretch.
  function automatic bit pick_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 1'b0;
    end
    return $urandom_range(0, 99) < 22;
  endfunction

  // Driver: present the next queued beat, hold it until accepted, and feed each
  // accepted beat to the search model.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.op          <= ipr_pkg::OP_LOAD;
      in_if.entry_index <= '0;
      in_if.range_start <= '0;
      in_if.range_end   <= '0;
      in_if.query_addr  <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        lookup_q.push_back(search_ranges({in_if.op, in_if.entry_index, in_if.range_start,
                                          in_if.range_end, in_if.query_addr}));
      end
      if (!in_if.valid || in_if.ready) begin
        if (beat_q.size() != 0 && !pick_gap(src_calm)) begin
          next_beat          = beat_q.pop_front();
          in_if.valid       <= 1'b1;
          in_if.op          <= next_beat.op;
          in_if.entry_index <= next_beat.entry_index;
          in_if.range_start <= next_beat.range_start;
          in_if.range_end   <= next_beat.range_end;
          in_if.query_addr  <= next_beat.query_addr;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random and compare every result beat, field by field,
  // with the oldest owed result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (lookup_q.size() == 0) begin
          if (fail_cnt < MAX_REPORTS)
            $display("%0t: unexpected result beat: expected none, actual found=%0b index=%0d",
                     $time, out_if.found, out_if.match_index);
          fail_cnt++;
        end else begin
          want = lookup_q.pop_front();
          if (out_if.found !== want.found) begin
            if (fail_cnt < MAX_REPORTS)
              $display("%0t: found mismatch: expected %0b actual %0b",
                       $time, want.found, out_if.found);
            fail_cnt++;
          end
          if (out_if.match_index !== want.match_index) begin
            if (fail_cnt < MAX_REPORTS)
              $display("%0t: match_index mismatch: expected %0d actual %0d",
                       $time, want.match_index, out_if.match_index);
            fail_cnt++;
          end
        end
      end
      out_if.ready <= !pick_gap(sink_calm);
    end
  end

  // Queue a load; the unused query field carries noise.
  task automatic push_load(input int unsigned idx, input logic [ipr_pkg::ADDR_W-1:0] s,
                           input logic [ipr_pkg::ADDR_W-1:0] e);
    range_beat_t b;
    b.op          = ipr_pkg::OP_LOAD;
    b.entry_index = ipr_pkg::IDX_W'(idx);
    b.range_start = s;
    b.range_end   = e;
    b.query_addr  = $urandom;
    plan_start[b.entry_index] = s;
    plan_end[b.entry_index]   = e;
    beat_q.push_back(b);
  endtask

  // Queue a query; the unused load fields carry noise.
  task automatic push_query(input logic [ipr_pkg::ADDR_W-1:0] addr);
    range_beat_t b;
    b.op          = ipr_pkg::OP_QUERY;
    b.entry_index = ipr_pkg::IDX_W'($urandom);
    b.range_start = $urandom;
    b.range_end   = $urandom;
    b.query_addr  = addr;
    beat_q.push_back(b);
  endtask

  // Block until no beat is queued, on the bus, or owed a result.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (beat_q.size() != 0 || in_if.valid || lookup_q.size() != 0);
  endtask

  // Write record_count only once the block has drained.
  task automatic set_count(input int unsigned v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ipr_pkg::COUNT_W'(v);
    rec_count    = ipr_pkg::COUNT_W'(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Load entries [0, n) in the given shape, in ascending or descending order.
  // Sorted starts advance by at most 2^32 / (n + 1) so they never wrap.
  task automatic fill_table(input int unsigned n, input fill_style_e style);
    longint unsigned            cur;
    longint unsigned            step;
    logic [ipr_pkg::ADDR_W-1:0] s_arr [];
    logic [ipr_pkg::ADDR_W-1:0] e_arr [];
    bit                         down;
    s_arr = new[n];
    e_arr = new[n];
    step  = 64'hFFFF_FFFF / (n + 1);
    cur   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 32'(step));
    for (int unsigned i = 0; i < n; i++) begin
      if (style == FILL_SCRAMBLED) begin
        s_arr[i] = $urandom;
        e_arr[i] = $urandom;
      end else begin
        s_arr[i] = ipr_pkg::ADDR_W'(cur);
        e_arr[i] = ($urandom_range(0, 15) == 0) ? ipr_pkg::ADDR_W'($urandom)
                                                 : s_arr[i] + $urandom_range(0, 32'(step));
        // Duplicate starts: hold the cursor so the next entry shares this start.
        if (!(style == FILL_DUP_STARTS && $urandom_range(0, 2) == 0))
          cur += $urandom_range(1, 32'(step));
      end
    end
    down = $urandom_range(0, 1);
    for (int unsigned i = 0; i < n; i++) begin
      if (down) push_load(n - 1 - i, s_arr[n-1-i], e_arr[n-1-i]);
      else push_load(i, s_arr[i], e_arr[i]);
    end
  endtask

  // Aim a query at the edges of a range in [0, n) most of the time.
  function automatic logic [ipr_pkg::ADDR_W-1:0] pick_addr(input int unsigned n);
    int unsigned                k;
    logic [ipr_pkg::ADDR_W-1:0] s;
    logic [ipr_pkg::ADDR_W-1:0] e;
    if (n == 0 || $urandom_range(0, 9) == 0) return $urandom;
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1) ? '1 : '0;
    k = $urandom_range(0, n - 1);
    s = plan_start[k];
    e = plan_end[k];
    case ($urandom_range(0, 4))
      0: return s;
      1: return e;
      2: return s - 1;
      3: return e + 1;
      default: return (e >= s) ? s + $urandom_range(0, e - s) : s;
    endcase
  endfunction

  initial begin
    int unsigned n;
    int unsigned cnt;
    int unsigned burst;
    fill_style_e style;

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    rec_count         = '0;
    in_if.valid       = 1'b0;
    in_if.op          = ipr_pkg::OP_LOAD;
    in_if.entry_index = '0;
    in_if.range_start = '0;
    in_if.range_end   = '0;
    in_if.query_addr  = '0;
    out_if.ready      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table: every query misses.
    push_query('0);
    push_query('1);

    // Load results, top table slot, and a one-entry table.
    push_load(0, 32'h0A00_0000, 32'h0A00_00FF);
    push_load(ipr_pkg::TABLE_DEPTH - 1, '1, '1);
    set_count(1);
    push_query(32'h09FF_FFFF);   // below every start
    push_query(32'h0A00_0000);
    push_query(32'h0A00_00FF);
    push_query(32'h0A00_0100);   // just past the end
    push_query('1);

    // Duplicate starts: the last of them is chosen, and its end decides.
    push_load(1, 32'h0B00_0000, 32'h0B00_00FF);
    push_load(2, 32'h0B00_0000, 32'h0B00_000F);
    set_count(3);
    push_query(32'h0B00_0080);
    push_query(32'h0B00_0005);

    // Full count over a sparse sorted table: load only the entries that the
    // searches for the lowest and the highest addresses visit.
    for (int unsigned k = 1; k < ipr_pkg::TABLE_DEPTH; k = k * 2) begin
      push_load(k, ipr_pkg::ADDR_W'(k) << 20,
                (ipr_pkg::ADDR_W'(k) << 20) + 32'h0000_FFFF);
      push_load(ipr_pkg::TABLE_DEPTH - k, ipr_pkg::ADDR_W'(ipr_pkg::TABLE_DEPTH - k) << 20,
                (ipr_pkg::ADDR_W'(ipr_pkg::TABLE_DEPTH - k) << 20) + 32'h0000_FFFF);
    end
    push_load(0, '0, 32'h0000_FFFF);
    push_load(ipr_pkg::TABLE_DEPTH - 1,
              ipr_pkg::ADDR_W'(ipr_pkg::TABLE_DEPTH - 1) << 20, '1);
    set_count(ipr_pkg::TABLE_DEPTH);
    push_query('0);
    push_query(32'h0001_0000);   // just past the end of entry 0
    push_query('1);
    push_query(ipr_pkg::ADDR_W'(ipr_pkg::TABLE_DEPTH - 1) << 20);
    push_query((ipr_pkg::ADDR_W'(ipr_pkg::TABLE_DEPTH - 2) << 20) + 32'h0001_0000);

    // Count above the table depth saturates.
    set_count((1 << ipr_pkg::COUNT_W) - 1);
    push_query('1);
    push_query('0);

    // One long stretch with no idling on either side.
    src_calm  = 300;
    sink_calm = 2000;

    // Random phases: rebuild a small table, set the count, then mostly queries
    // with a sprinkling of stray loads. Queries reach only rebuilt entries.
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       n = 0;
        1, 2, 3: n = 1;
        default: n = $urandom_range(2, 64);
      endcase
      if (n > 0) begin
        case ($urandom_range(0, 9))
          7:       style = FILL_DUP_STARTS;
          8, 9:    style = FILL_SCRAMBLED;
          default: style = FILL_SORTED;
        endcase
        fill_table(n, style);
        rand_items += n;
      end
      cnt = n;
      if (n > 0 && $urandom_range(0, 7) == 0)
        cnt = $urandom_range(0, n - 1);
      set_count(cnt);
      burst = $urandom_range(10, 60);
      for (int unsigned i = 0; i < burst; i++) begin
        if ($urandom_range(0, 99) < 85) push_query(pick_addr(n));
        else push_load($urandom_range(0, ipr_pkg::TABLE_DEPTH - 1), $urandom, $urandom);
      end
      rand_items += burst;
    end

    // Drain, then give a stray beat time to show up.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && lookup_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #(20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
